### hdl/spr_pkg.sv
package spr_pkg;

   localparam int NUM_MOTORS_DEFAULT = 4;

   localparam int OPCODE_W = 2;
   localparam int MOTOR_W  = 2;
   localparam int COUNT_W  = 16;
   localparam int MASK_W   = 4;
   localparam int PERIOD_W = 16;
   localparam int CMP_W    = 15;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [PERIOD_W-1:0] RESET_START_PERIOD  = 16'd1000;
   localparam logic [PERIOD_W-1:0] RESET_TARGET_PERIOD = 16'd300;
   localparam logic [PERIOD_W-1:0] RESET_RAMP_INTERVAL = 16'd200;
   localparam logic [PERIOD_W-1:0] RESET_PERIOD_STEP   = 16'd50;
   localparam logic [PERIOD_W-1:0] RESET_PERIOD        = 16'd1000;
   localparam logic [PERIOD_W-1:0] MIN_PERIOD          = 16'd2;

   typedef enum logic [OPCODE_W-1:0] {
      OP_TICK  = 2'd0,
      OP_START = 2'd1,
      OP_STOP  = 2'd2
   } spr_opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_PERIOD  = 2'd0,
      CSR_TARGET_PERIOD = 2'd1,
      CSR_RAMP_INTERVAL = 2'd2,
      CSR_PERIOD_STEP   = 2'd3
   } spr_csr_index_type;

   // Decoded command; start and stop are only set for a motor that exists.
   typedef struct packed {
      logic                 tick;
      logic                 start;
      logic                 stop;
      logic [MOTOR_W-1:0]   motor;
      logic [COUNT_W-1:0]   count;
      logic                 dir;
      logic                 lin;
      logic                 restart;
   } spr_cmd_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] start_period;
      logic [PERIOD_W-1:0] target_period;
      logic [PERIOD_W-1:0] ramp_interval;
      logic [PERIOD_W-1:0] period_step;
   } spr_cfg_type;

   function automatic logic [PERIOD_W-1:0] clamp_period(input logic [PERIOD_W-1:0] p);
      return (p < MIN_PERIOD) ? MIN_PERIOD : p;
   endfunction

endpackage

### hdl/spr_motor_bank.sv
module spr_motor_bank #(
   parameter int NUM_MOTORS = spr_pkg::NUM_MOTORS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fire,
   input  spr_pkg::spr_cmd_type        cmd,
   output logic [spr_pkg::MASK_W-1:0]  enable_mask_in,
   output logic [spr_pkg::MASK_W-1:0]  direction_mask_in,
   output logic [spr_pkg::MASK_W-1:0]  finished_mask_in,
   output logic                        any_target_in
);

   localparam int EXT_W = (NUM_MOTORS > spr_pkg::MASK_W) ? NUM_MOTORS : spr_pkg::MASK_W;

   logic [spr_pkg::COUNT_W-1:0] target_ff [NUM_MOTORS];
   logic [spr_pkg::COUNT_W-1:0] done_ff   [NUM_MOTORS];
   logic [spr_pkg::COUNT_W-1:0] target_in [NUM_MOTORS];
   logic [spr_pkg::COUNT_W-1:0] done_in   [NUM_MOTORS];
   logic [NUM_MOTORS-1:0]       en_ff, en_in;
   logic [NUM_MOTORS-1:0]       dir_ff, dir_in;
   logic [NUM_MOTORS-1:0]       fin;
   logic [EXT_W-1:0]            en_ext, dir_ext, fin_ext;

   always_comb begin
      logic                        sel;
      logic [spr_pkg::COUNT_W-1:0] done_inc;
      any_target_in = 1'b0;
      for (int i = 0; i < NUM_MOTORS; i++) begin
         sel = ({30'd0, cmd.motor} == 32'(i));
         done_inc = done_ff[i] + 1'b1;
         target_in[i] = target_ff[i];
         done_in[i]   = done_ff[i];
         en_in[i]     = en_ff[i];
         dir_in[i]    = dir_ff[i];
         fin[i]       = 1'b0;
         if (cmd.tick) begin
            if (target_ff[i] != '0) begin
               done_in[i] = done_inc;
               if (done_inc >= target_ff[i]) begin
                  en_in[i]     = 1'b0;
                  target_in[i] = '0;
                  fin[i]       = 1'b1;
               end
            end
         end else if (sel && cmd.start) begin
            dir_in[i] = cmd.dir;
            if (cmd.count == '0) begin
               en_in[i]     = 1'b0;
               target_in[i] = '0;
               done_in[i]   = '0;
            end else begin
               en_in[i]     = 1'b1;
               target_in[i] = cmd.count;
               done_in[i]   = '0;
            end
         end else if (sel && cmd.stop) begin
            en_in[i]     = 1'b0;
            target_in[i] = '0;
            done_in[i]   = '0;
         end
         if (target_in[i] != '0) begin
            any_target_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff  <= '0;
         dir_ff <= '0;
         for (int i = 0; i < NUM_MOTORS; i++) begin
            target_ff[i] <= '0;
            done_ff[i]   <= '0;
         end
      end else if (fire) begin
         en_ff  <= en_in;
         dir_ff <= dir_in;
         for (int i = 0; i < NUM_MOTORS; i++) begin
            target_ff[i] <= target_in[i];
            done_ff[i]   <= done_in[i];
         end
      end
   end

   // Masks are fixed at four bits; motors beyond that are not reported.
   assign en_ext  = EXT_W'(en_in);
   assign dir_ext = EXT_W'(dir_in);
   assign fin_ext = EXT_W'(fin);
   assign enable_mask_in    = en_ext[spr_pkg::MASK_W-1:0];
   assign direction_mask_in = dir_ext[spr_pkg::MASK_W-1:0];
   assign finished_mask_in  = fin_ext[spr_pkg::MASK_W-1:0];

endmodule

### hdl/spr_ramp.sv
module spr_ramp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  spr_pkg::spr_cmd_type          cmd,
   input  spr_pkg::spr_cfg_type          cfg,
   input  logic                          any_target_in,
   output logic [spr_pkg::PERIOD_W-1:0]  period_in,
   output logic                          armed_in
);

   logic [spr_pkg::PERIOD_W-1:0] period_ff;
   logic [spr_pkg::PERIOD_W-1:0] ticks_ff, ticks_in;
   logic                         armed_ff;
   logic                         linear_ff, linear_in;
   logic                         fresh_ff, fresh_in;

   always_comb begin
      logic [spr_pkg::PERIOD_W-1:0] ticks_inc;
      logic [spr_pkg::PERIOD_W-1:0] np;
      logic                         fresh_eff;
      ticks_inc = ticks_ff + 1'b1;
      np = (period_ff > cfg.period_step) ? (period_ff - cfg.period_step) : '0;
      if (np < cfg.target_period) begin
         np = cfg.target_period;
      end
      fresh_eff = fresh_ff | cmd.restart;
      period_in = period_ff;
      ticks_in  = ticks_ff;
      armed_in  = armed_ff;
      linear_in = linear_ff;
      fresh_in  = fresh_ff;
      if (cmd.tick) begin
         if (linear_ff && armed_ff) begin
            if (any_target_in) begin
               ticks_in = ticks_inc;
               if (ticks_inc >= cfg.ramp_interval) begin
                  ticks_in = '0;
                  if (period_ff > cfg.target_period) begin
                     period_in = spr_pkg::clamp_period(np);
                  end else begin
                     armed_in = 1'b0;
                  end
               end
            end else begin
               armed_in = 1'b0;
            end
         end
      end else if (cmd.start) begin
         linear_in = cmd.lin;
         fresh_in  = fresh_eff;
         if (cmd.count == '0) begin
            if (!any_target_in) begin
               fresh_in = 1'b1;
               armed_in = 1'b0;
            end
         end else if (fresh_eff) begin
            period_in = spr_pkg::clamp_period(cfg.start_period);
            armed_in  = cmd.lin;
            if (cmd.lin) begin
               ticks_in = '0;
            end
            fresh_in = 1'b0;
         end
      end else if (cmd.stop) begin
         if (!any_target_in) begin
            fresh_in = 1'b1;
            armed_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= spr_pkg::RESET_PERIOD;
         ticks_ff  <= '0;
         armed_ff  <= 1'b0;
         linear_ff <= 1'b1;
         fresh_ff  <= 1'b1;
      end else if (fire) begin
         period_ff <= period_in;
         ticks_ff  <= ticks_in;
         armed_ff  <= armed_in;
         linear_ff <= linear_in;
         fresh_ff  <= fresh_in;
      end
   end

endmodule

### hdl/stepper_pulse_ramp_controller.sv
// Channel   Direction  Handshake              Contents
// req_      in         req_valid/req_ready    opcode, motor, pulse count, direction, mode, restart
// rsp_      out        rsp_valid/rsp_ready    enable/direction/finished masks, reload, compare, flags
// csr_      in         csr_valid/csr_ready    register index and 16-bit write data
//
// A request transfer lands in an input register; once the result register is free or being
// emptied, the motor bank and the ramp unit work it out in one pass and the result register
// takes it. A new item can therefore follow in every cycle while responses are not stalled.
// Reset is synchronous and active high; it restores all configuration and motor state.
// A stalled response holds its register; the input register then waits, and the request
// channel is only held off once both registers are full. The CSR port is always ready.
module stepper_pulse_ramp_controller #(
   parameter int NUM_MOTORS = spr_pkg::NUM_MOTORS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [spr_pkg::OPCODE_W-1:0]    req_opcode,
   input  logic [spr_pkg::MOTOR_W-1:0]     req_motor,
   input  logic [spr_pkg::COUNT_W-1:0]     req_pulse_count,
   input  logic                            req_direction,
   input  logic                            req_linear_move,
   input  logic                            req_restart_ramp,

   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [spr_pkg::MASK_W-1:0]      rsp_enable_mask,
   output logic [spr_pkg::MASK_W-1:0]      rsp_direction_mask,
   output logic [spr_pkg::MASK_W-1:0]      rsp_finished_mask,
   output logic [spr_pkg::PERIOD_W-1:0]    rsp_reload_value,
   output logic [spr_pkg::CMP_W-1:0]       rsp_compare_value,
   output logic                            rsp_any_running,
   output logic                            rsp_ramp_active,

   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [spr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [spr_pkg::CSR_DATA_W-1:0]  csr_data
);

   // Configuration registers.
   spr_pkg::spr_cfg_type cfg_ff;

   // Input register: holds one accepted request until it is worked out.
   logic                          in_valid_ff;
   logic [spr_pkg::OPCODE_W-1:0]  in_opcode_ff;
   logic [spr_pkg::MOTOR_W-1:0]   in_motor_ff;
   logic [spr_pkg::COUNT_W-1:0]   in_count_ff;
   logic                          in_dir_ff;
   logic                          in_lin_ff;
   logic                          in_restart_ff;

   // Result register.
   logic                          out_valid_ff;
   logic [spr_pkg::MASK_W-1:0]    out_en_ff, out_dir_ff, out_fin_ff;
   logic [spr_pkg::PERIOD_W-1:0]  out_reload_ff;
   logic                          out_any_ff, out_armed_ff;

   logic                          fire;
   logic                          motor_ok;
   spr_pkg::spr_cmd_type          cmd;
   logic [spr_pkg::MASK_W-1:0]    en_mask_in, dir_mask_in, fin_mask_in;
   logic                          any_target_in;
   logic [spr_pkg::PERIOD_W-1:0]  period_in;
   logic                          armed_in;
   logic [spr_pkg::PERIOD_W-1:0]  reload_in;

   // The held item is worked out whenever the result register is free or being emptied.
   assign fire      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;
   assign csr_ready = 1'b1;

   assign motor_ok = ({30'd0, in_motor_ff} < 32'(NUM_MOTORS));

   // Decode; an unused opcode leaves every flag low, and a start or stop for a motor that does
   // not exist leaves its flag low, so such an item only reports the present state.
   always_comb begin
      cmd         = '0;
      cmd.motor   = in_motor_ff;
      cmd.count   = in_count_ff;
      cmd.dir     = in_dir_ff;
      cmd.lin     = in_lin_ff;
      cmd.restart = in_restart_ff;
      case (in_opcode_ff)
         spr_pkg::OP_TICK:  cmd.tick  = 1'b1;
         spr_pkg::OP_START: cmd.start = motor_ok;
         spr_pkg::OP_STOP:  cmd.stop  = motor_ok;
         default:           cmd.tick  = 1'b0;
      endcase
   end

   spr_motor_bank #(
      .NUM_MOTORS (NUM_MOTORS)
   ) u_motor_bank (
      .clock             (clock),
      .reset             (reset),
      .fire              (fire),
      .cmd               (cmd),
      .enable_mask_in    (en_mask_in),
      .direction_mask_in (dir_mask_in),
      .finished_mask_in  (fin_mask_in),
      .any_target_in     (any_target_in)
   );

   spr_ramp u_ramp (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .cmd           (cmd),
      .cfg           (cfg_ff),
      .any_target_in (any_target_in),
      .period_in     (period_in),
      .armed_in      (armed_in)
   );

   // The period never drops below two, so the reload value never wraps.
   assign reload_in = period_in - 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_period  <= spr_pkg::RESET_START_PERIOD;
         cfg_ff.target_period <= spr_pkg::RESET_TARGET_PERIOD;
         cfg_ff.ramp_interval <= spr_pkg::RESET_RAMP_INTERVAL;
         cfg_ff.period_step   <= spr_pkg::RESET_PERIOD_STEP;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            spr_pkg::CSR_START_PERIOD:  cfg_ff.start_period  <= csr_data;
            spr_pkg::CSR_TARGET_PERIOD: cfg_ff.target_period <= csr_data;
            spr_pkg::CSR_RAMP_INTERVAL: cfg_ff.ramp_interval <= csr_data;
            spr_pkg::CSR_PERIOD_STEP:   cfg_ff.period_step   <= csr_data;
            default:                    cfg_ff.period_step   <= cfg_ff.period_step;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_opcode_ff  <= req_opcode;
         in_motor_ff   <= req_motor;
         in_count_ff   <= req_pulse_count;
         in_dir_ff     <= req_direction;
         in_lin_ff     <= req_linear_move;
         in_restart_ff <= req_restart_ramp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_en_ff     <= en_mask_in;
         out_dir_ff    <= dir_mask_in;
         out_fin_ff    <= fin_mask_in;
         out_reload_ff <= reload_in;
         out_any_ff    <= any_target_in;
         out_armed_ff  <= armed_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_enable_mask    = out_en_ff;
   assign rsp_direction_mask = out_dir_ff;
   assign rsp_finished_mask  = out_fin_ff;
   assign rsp_reload_value   = out_reload_ff;
   assign rsp_compare_value  = out_reload_ff[spr_pkg::PERIOD_W-1:1];
   assign rsp_any_running    = out_any_ff;
   assign rsp_ramp_active    = out_armed_ff;

endmodule
